// ===== design/ght_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types, constants and helper functions of the handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 1024;
    localparam int BM_W       = 32;
    localparam int BM_LW      = 5;
    localparam int WORD_CNT   = (SLOT_COUNT + BM_W - 1) / BM_W;
    localparam int WORD_AW    = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;
    localparam int IDX_W      = WORD_AW + BM_LW;
    localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int STS_W   = 2;
    localparam int HDL_W   = 32;
    localparam int HALF_W  = 16;
    localparam int PL_W    = 32;
    localparam int CHK_W   = 16;
    localparam int ENTRY_W = CHK_W + PL_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    // Status codes.
    localparam logic [STS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL    = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic accept;
        logic finish;
    } t_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_free;
    } t_sts;

    // Bits of the last bitmap word that lie past the end of the table.
    function automatic logic [BM_W-1:0] last_pad_mask();
        logic [BM_W-1:0] m;
        m = '0;
        for (int b = 0; b < BM_W; b++) begin
            if ((WORD_CNT - 1) * BM_W + b >= SLOT_COUNT) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    localparam logic [BM_W-1:0]    LAST_PAD  = last_pad_mask();
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_CNT - 1);

    // Lowest clear bit of the word-full summary.
    function automatic logic [WORD_AW-1:0] first_zero_word(input logic [WORD_CNT-1:0] v);
        logic [WORD_AW-1:0] idx;
        idx = '0;
        for (int i = WORD_CNT - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = WORD_AW'(i);
            end
        end
        return idx;
    endfunction

    // Lowest clear bit of one bitmap word.
    function automatic logic [BM_LW-1:0] first_zero_bit(input logic [BM_W-1:0] v);
        logic [BM_LW-1:0] idx;
        idx = '0;
        for (int i = BM_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                idx = BM_LW'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

// ===== design/ght_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ght_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== design/ght_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ght_ctrl
// Controller: clearing pass after reset, then accept and commit of each beat.
// ----------------------------------------------------------------------------
module ght_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire ght_pkg::t_sts i_sts,
    output ght_pkg::t_ctl      o_ctl,
    output logic               o_in_stall
);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        o_ctl.clr_step = 1'b0;
        o_ctl.accept   = 1'b0;
        o_ctl.finish   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.accept = 1'b1;
                    n_state      = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_ctl.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Input is taken only in the idle state.
    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ===== design/ght_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ght_dp
// Datapath: occupancy bitmap with word-full summary, slot store, stamp
// counter and the output register.
// ----------------------------------------------------------------------------
module ght_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ght_pkg::t_ctl                 i_ctl,
    output ght_pkg::t_sts                      o_sts,
    input  wire logic [ght_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [ght_pkg::HDL_W-1:0]     i_handle,
    input  wire logic [ght_pkg::PL_W-1:0]      i_payload,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic      [ght_pkg::STS_W-1:0]     o_status,
    output logic      [ght_pkg::HDL_W-1:0]     o_handle_out,
    output logic      [ght_pkg::PL_W-1:0]      o_payload_out
);

    // Captured command.
    logic [ght_pkg::CMD_W-1:0]    r_cmd;
    logic [ght_pkg::HDL_W-1:0]    r_handle;
    logic [ght_pkg::PL_W-1:0]     r_payload;
    logic [ght_pkg::WORD_AW-1:0]  r_word_sel;
    logic                         r_full;
    logic                         r_range_ok;

    // Table control state.
    logic [ght_pkg::CHK_W-1:0]    r_stamp;
    logic [ght_pkg::WORD_CNT-1:0] r_summary;
    logic [ght_pkg::WORD_AW-1:0]  r_clr_addr;

    // Output register.
    logic                         r_out_valid;
    logic [ght_pkg::STS_W-1:0]    r_status;
    logic [ght_pkg::HDL_W-1:0]    r_handle_out;
    logic [ght_pkg::PL_W-1:0]     r_payload_out;

    // Accept-side address generation.
    logic [ght_pkg::WORD_AW-1:0]  free_word;
    logic [ght_pkg::IDX_W-1:0]    in_idx;
    logic [ght_pkg::WORD_AW-1:0]  rd_word;
    logic                         in_range;

    // Commit-side decode.
    logic [ght_pkg::BM_W-1:0]     bm_rdata;
    logic [ght_pkg::ENTRY_W-1:0]  slot_rdata;
    logic [ght_pkg::BM_W-1:0]     bm_eff;
    logic [ght_pkg::BM_LW-1:0]    free_bit;
    logic [ght_pkg::BM_W-1:0]     alloc_word;
    logic [ght_pkg::BM_LW-1:0]    hdl_bit;
    logic [ght_pkg::BM_W-1:0]     rel_word;
    logic [ght_pkg::IDX_W-1:0]    alloc_idx;
    logic                         hit;
    logic                         alloc_ok;
    logic                         rel_ok;
    logic                         look_ok;

    // RAM port signals.
    logic                         bm_we;
    logic [ght_pkg::WORD_AW-1:0]  bm_waddr;
    logic [ght_pkg::BM_W-1:0]     bm_wdata;
    logic                         slot_we;

    // Pick the word to read: lowest non-full word on allocate, else the handle's.
    always_comb begin
        free_word = ght_pkg::first_zero_word(r_summary);
        in_idx    = i_handle[ght_pkg::HALF_W +: ght_pkg::IDX_W];
        in_range  = ({1'b0, i_handle[ght_pkg::HDL_W-1:ght_pkg::HALF_W]}
                     < (ght_pkg::HALF_W + 1)'(ght_pkg::SLOT_COUNT));
        if (i_cmd == ght_pkg::CMD_ALLOC) begin
            rd_word = free_word;
        end else begin
            rd_word = in_idx[ght_pkg::IDX_W-1:ght_pkg::BM_LW];
        end
    end

    // Capture the command and the read-time flags.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_cmd      <= i_cmd;
            r_handle   <= i_handle;
            r_payload  <= i_payload;
            r_word_sel <= rd_word;
            r_full     <= &r_summary;
            r_range_ok <= in_range;
        end
    end

    // Decode the read data and form the commit.
    always_comb begin
        if (r_word_sel == ght_pkg::LAST_WORD) begin
            bm_eff = bm_rdata | ght_pkg::LAST_PAD;
        end else begin
            bm_eff = bm_rdata;
        end
        free_bit   = ght_pkg::first_zero_bit(bm_eff);
        alloc_word = bm_rdata | (ght_pkg::BM_W'(1) << free_bit);
        alloc_idx  = {r_word_sel, free_bit};
        hdl_bit    = r_handle[ght_pkg::HALF_W +: ght_pkg::BM_LW];
        rel_word   = bm_rdata & ~(ght_pkg::BM_W'(1) << hdl_bit);
        hit        = r_range_ok && bm_rdata[hdl_bit]
                     && (slot_rdata[ght_pkg::ENTRY_W-1:ght_pkg::PL_W]
                         == r_handle[ght_pkg::CHK_W-1:0]);
        alloc_ok   = (r_cmd == ght_pkg::CMD_ALLOC) && !r_full;
        rel_ok     = (r_cmd == ght_pkg::CMD_RELEASE) && hit;
        look_ok    = (r_cmd == ght_pkg::CMD_LOOKUP) && hit;
    end

    // Bitmap write: clearing pass or commit.
    always_comb begin
        bm_we    = i_ctl.clr_step || (i_ctl.finish && (alloc_ok || rel_ok));
        bm_waddr = i_ctl.clr_step ? r_clr_addr : r_word_sel;
        if (i_ctl.clr_step) begin
            bm_wdata = '0;
        end else if (alloc_ok) begin
            bm_wdata = alloc_word;
        end else begin
            bm_wdata = rel_word;
        end
        slot_we = i_ctl.finish && alloc_ok;
    end

    ght_ram #(
        .WIDTH (ght_pkg::BM_W),
        .DEPTH (ght_pkg::WORD_CNT)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (bm_we),
        .i_wr_addr (bm_waddr),
        .i_wr_data (bm_wdata),
        .i_rd_en   (i_ctl.accept),
        .i_rd_addr (rd_word),
        .o_rd_data (bm_rdata)
    );

    ght_ram #(
        .WIDTH (ght_pkg::ENTRY_W),
        .DEPTH (ght_pkg::SLOT_COUNT)
    ) u_slots (
        .i_clk     (i_clk),
        .i_wr_en   (slot_we),
        .i_wr_addr (alloc_idx[ght_pkg::SLOT_AW-1:0]),
        .i_wr_data ({r_stamp, r_payload}),
        .i_rd_en   (i_ctl.accept),
        .i_rd_addr (in_idx[ght_pkg::SLOT_AW-1:0]),
        .o_rd_data (slot_rdata)
    );

    // Clearing address, stamp counter and word-full summary.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_stamp    <= ght_pkg::CHK_W'(1);
            r_summary  <= '0;
        end else begin
            if (i_ctl.clr_step) begin
                r_clr_addr <= r_clr_addr + ght_pkg::WORD_AW'(1);
            end
            if (i_ctl.finish && alloc_ok) begin
                r_stamp               <= r_stamp + ght_pkg::CHK_W'(1);
                r_summary[r_word_sel] <= &(alloc_word | (bm_eff ^ bm_rdata));
            end else if (i_ctl.finish && rel_ok) begin
                r_summary[r_word_sel] <= 1'b0;
            end
        end
    end

    // Output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; every arm loads all three result fields once.
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            unique case (r_cmd)
                ght_pkg::CMD_ALLOC: begin
                    r_payload_out <= '0;
                    if (alloc_ok) begin
                        r_status     <= ght_pkg::ST_OK;
                        r_handle_out <= {ght_pkg::HALF_W'(alloc_idx), r_stamp};
                    end else begin
                        r_status     <= ght_pkg::ST_FULL;
                        r_handle_out <= '0;
                    end
                end
                ght_pkg::CMD_RELEASE: begin
                    r_status      <= rel_ok ? ght_pkg::ST_OK : ght_pkg::ST_INVALID;
                    r_handle_out  <= '0;
                    r_payload_out <= '0;
                end
                ght_pkg::CMD_LOOKUP: begin
                    r_handle_out <= '0;
                    if (look_ok) begin
                        r_status      <= ght_pkg::ST_OK;
                        r_payload_out <= slot_rdata[ght_pkg::PL_W-1:0];
                    end else begin
                        r_status      <= ght_pkg::ST_INVALID;
                        r_payload_out <= '0;
                    end
                end
                default: begin
                    r_status      <= ght_pkg::ST_INVALID;
                    r_handle_out  <= '0;
                    r_payload_out <= '0;
                end
            endcase
        end
    end

    assign o_sts.clr_last = (r_clr_addr == ght_pkg::LAST_WORD);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_handle_out   = r_handle_out;
    assign o_payload_out  = r_payload_out;

endmodule
`default_nettype wire

// ===== design/generational_handle_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generational_handle_table
// Handle table with generation checks: allocate, release and lookup of
// slots named by an index and a 16-bit check value.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Fields
//   command   in         i_in_valid / o_in_stall   i_cmd, i_handle, i_payload
//   result    out        o_out_valid / i_out_stall o_status, o_handle_out,
//                                                  o_payload_out
//
// The accept edge reads the occupancy bitmap word and the slot entry from
// the two RAMs, whose read is registered; the commit edge then writes the
// slot update and loads the result register. No new command is taken before
// that commit. After reset the bitmap is cleared one word a cycle (32 words
// for 1024 slots) while o_in_stall is high. A stalled result holds the next
// command in its commit cycle until the result register is free.
// ----------------------------------------------------------------------------
module generational_handle_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [ght_pkg::CMD_W-1:0] i_cmd,
    input  wire logic [ght_pkg::HDL_W-1:0] i_handle,
    input  wire logic [ght_pkg::PL_W-1:0]  i_payload,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [ght_pkg::STS_W-1:0] o_status,
    output logic      [ght_pkg::HDL_W-1:0] o_handle_out,
    output logic      [ght_pkg::PL_W-1:0]  o_payload_out
);

    ght_pkg::t_ctl ctl;
    ght_pkg::t_sts sts;

    // Sequencer.
    ght_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    // Table storage and result path.
    ght_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_cmd         (i_cmd),
        .i_handle      (i_handle),
        .i_payload     (i_payload),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .o_handle_out  (o_handle_out),
        .o_payload_out (o_payload_out)
    );

endmodule
`default_nettype wire

// ===== dv/generational_handle_table_test.sv =====
// ----------------------------------------------------------------------------
// generational_handle_table_test
// Self-checking bench for the handle table. A directed table of commands
// covers the extremes, every command code and the error paths. Random traffic
// then fills the table to the full condition and frees slots again. Every
// result beat is checked in order against the result written out in its
// typed directed row, or else against a behavioral model kept in the bench.
// ----------------------------------------------------------------------------
module generational_handle_table_test;

    // The command code that the block must reject.
    localparam logic [ght_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int LONG_HOLD   = 400;
    localparam int RETIRED_MAX = 64;

    typedef struct packed {
        logic [ght_pkg::STS_W-1:0] status;
        logic [ght_pkg::HDL_W-1:0] handle_out;
        logic [ght_pkg::PL_W-1:0]  payload_out;
    } t_result;

    typedef struct packed {
        logic [ght_pkg::CMD_W-1:0] cmd;
        logic [ght_pkg::HDL_W-1:0] handle;
        logic [ght_pkg::PL_W-1:0]  payload;
        logic                      typed;
        t_result                   want;
    } t_cmd_row;

    // Directed commands; rows with typed set carry the result written out.
    localparam int DIR_ROWS = 24;
    localparam t_cmd_row DIRECTED [DIR_ROWS] = '{
        '{ght_pkg::CMD_LOOKUP,  32'h0000_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_RELEASE, 32'h0000_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{CMD_UNUSED,           32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_ALLOC,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{ght_pkg::ST_OK, 32'h0000_0001, 32'h0}},
        '{ght_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_OK, 32'h0001_0002, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0000_0001, 32'hFFFF_FFFF, 1'b1,
          '{ght_pkg::ST_OK, 32'h0, 32'hFFFF_FFFF}},
        '{ght_pkg::CMD_LOOKUP,  32'h0001_0002, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_OK, 32'h0, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0001_0003, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0400_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_RELEASE, 32'hFFFF_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_RELEASE, 32'h0000_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_OK, 32'h0, 32'h0}},
        '{ght_pkg::CMD_RELEASE, 32'h0000_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_ALLOC,   32'h0000_0000, 32'hA5A5_5A5A, 1'b1,
          '{ght_pkg::ST_OK, 32'h0000_0003, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0000_0001, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0000_0003, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_OK, 32'h0, 32'hA5A5_5A5A}},
        '{CMD_UNUSED,           32'h0000_0003, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0000_0003, 32'h0000_0000, 1'b0,
          '{ght_pkg::ST_OK, 32'h0, 32'h0}},
        '{ght_pkg::CMD_ALLOC,   32'h0000_0000, 32'h8000_0001, 1'b1,
          '{ght_pkg::ST_OK, 32'h0002_0004, 32'h0}},
        '{ght_pkg::CMD_RELEASE, 32'h0001_0002, 32'h0000_0000, 1'b0,
          '{ght_pkg::ST_OK, 32'h0, 32'h0}},
        '{ght_pkg::CMD_ALLOC,   32'h0000_0000, 32'h0000_0001, 1'b1,
          '{ght_pkg::ST_OK, 32'h0001_0005, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0001_0005, 32'h0000_0000, 1'b0,
          '{ght_pkg::ST_OK, 32'h0, 32'h0}},
        '{ght_pkg::CMD_RELEASE, 32'h03FF_0000, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h0000_0000, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}},
        '{ght_pkg::CMD_LOOKUP,  32'h03FF_FFFF, 32'h0000_0000, 1'b1,
          '{ght_pkg::ST_INVALID, 32'h0, 32'h0}}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic [ght_pkg::CMD_W-1:0] in_cmd = ght_pkg::CMD_ALLOC;
    logic [ght_pkg::HDL_W-1:0] in_handle = '0;
    logic [ght_pkg::PL_W-1:0]  in_payload = '0;
    logic                      out_stall = 1'b0;
    wire                       in_stall;
    wire                       out_valid;
    wire [ght_pkg::STS_W-1:0]  out_status;
    wire [ght_pkg::HDL_W-1:0]  out_handle;
    wire [ght_pkg::PL_W-1:0]   out_payload;

    // Model of the table as the bench sees it.
    logic                      table_valid [ght_pkg::SLOT_COUNT];
    logic [ght_pkg::CHK_W-1:0] table_check [ght_pkg::SLOT_COUNT];
    logic [ght_pkg::PL_W-1:0]  table_payload [ght_pkg::SLOT_COUNT];
    logic [ght_pkg::CHK_W-1:0] next_stamp;

    t_result                   pending_results [$];
    logic [ght_pkg::HDL_W-1:0] live_handles [$];
    logic [ght_pkg::HDL_W-1:0] retired_handles [$];
    t_result                   last_outcome;
    int                        mismatch_count = 0;
    int                        full_hits = 0;
    bit                        idle_en = 1'b1;
    int                        long_holds_asked = 0;

    generational_handle_table dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_cmd         (in_cmd),
        .i_handle      (in_handle),
        .i_payload     (in_payload),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_status      (out_status),
        .o_handle_out  (out_handle),
        .o_payload_out (out_payload)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 0;
    end

    // Applies one command to the model table and returns its result.
    function automatic t_result table_outcome(input logic [ght_pkg::CMD_W-1:0] cmd,
                                              input logic [ght_pkg::HDL_W-1:0] hdl,
                                              input logic [ght_pkg::PL_W-1:0]  pl);
        t_result     r;
        int unsigned idx;
        logic        hit;
        r   = '{ght_pkg::ST_INVALID, '0, '0};
        idx = hdl[31:16];
        hit = 1'b0;
        if (idx < ght_pkg::SLOT_COUNT) begin
            hit = table_valid[idx] && (table_check[idx] == hdl[15:0]);
        end
        case (cmd)
            ght_pkg::CMD_ALLOC: begin
                r.status = ght_pkg::ST_FULL;
                for (int i = 0; i < ght_pkg::SLOT_COUNT; i++) begin
                    if (!table_valid[i]) begin
                        table_valid[i]   = 1'b1;
                        table_check[i]   = next_stamp;
                        table_payload[i] = pl;
                        r.status         = ght_pkg::ST_OK;
                        r.handle_out     = {16'(i), next_stamp};
                        next_stamp       = next_stamp + 1'b1;
                        live_handles.insert(live_handles.size(), r.handle_out);
                        break;
                    end
                end
            end
            ght_pkg::CMD_RELEASE: begin
                if (hit) begin
                    table_valid[idx] = 1'b0;
                    r.status         = ght_pkg::ST_OK;
                    for (int k = 0; k < live_handles.size(); k++) begin
                        if (live_handles[k] == hdl) begin
                            live_handles.delete(k);
                            break;
                        end
                    end
                    retired_handles.insert(retired_handles.size(), hdl);
                    if (retired_handles.size() > RETIRED_MAX) begin
                        void'(retired_handles.pop_front());
                    end
                end
            end
            ght_pkg::CMD_LOOKUP: begin
                if (hit) begin
                    r.status      = ght_pkg::ST_OK;
                    r.payload_out = table_payload[idx];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Offers one command beat, waits for it to be taken and books its result.
    task automatic send_cmd(input logic [ght_pkg::CMD_W-1:0] cmd,
                            input logic [ght_pkg::HDL_W-1:0] hdl,
                            input logic [ght_pkg::PL_W-1:0] pl, input logic typed,
                            input t_result want);
        int gap;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_cmd     <= cmd;
        in_handle  <= hdl;
        in_payload <= pl;
        do @(posedge clk); while (in_stall);
        last_outcome = table_outcome(cmd, hdl, pl);
        if (last_outcome.status == ght_pkg::ST_FULL) full_hits++;
        pending_results.insert(pending_results.size(), typed ? want : last_outcome);
    endtask

    // One random command: weighted well-formed traffic, the rest malformed.
    task automatic send_random(input int alloc_w, input int release_w, input int lookup_w);
        int                        roll;
        logic [ght_pkg::CMD_W-1:0] c;
        logic [ght_pkg::HDL_W-1:0] h;
        roll = $urandom_range(0, 99);
        c    = $urandom_range(0, 1) ? ght_pkg::CMD_RELEASE : ght_pkg::CMD_LOOKUP;
        h    = $urandom;
        if (roll < alloc_w) begin
            c = ght_pkg::CMD_ALLOC;
        end else if (roll < alloc_w + release_w + lookup_w && live_handles.size() > 0) begin
            c = (roll < alloc_w + release_w) ? ght_pkg::CMD_RELEASE : ght_pkg::CMD_LOOKUP;
            h = live_handles[$urandom_range(0, live_handles.size() - 1)];
        end else begin
            case ($urandom_range(0, 4))
                0: c = CMD_UNUSED;
                1: if (retired_handles.size() > 0) begin
                    h = retired_handles[$urandom_range(0, retired_handles.size() - 1)];
                end
                2: ;
                3: h = {16'($urandom_range(0, ght_pkg::SLOT_COUNT - 1)), 16'($urandom)};
                default: if (live_handles.size() > 0) begin
                    h = live_handles[$urandom_range(0, live_handles.size() - 1)]
                        ^ {16'h0, 16'($urandom_range(1, 16'hFFFF))};
                end
            endcase
        end
        send_cmd(c, h, $urandom, 1'b0, '0);
    endtask

    // Result side: random stall bursts, plus long holds on request.
    initial begin : result_sink
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        forever begin
            @(negedge clk);
            if (holds_served < long_holds_asked) begin
                holds_served++;
                out_stall <= 1'b1;
                for (int n = 1; n < LONG_HOLD; n++) @(negedge clk);
                out_stall  <= 1'b0;
                stall_left = 0;
            end else begin
                if (stall_left > 0) begin
                    stall_left--;
                end else if (idle_en && $urandom_range(0, 5) == 0) begin
                    stall_left = $urandom_range(1, 17);
                end
                out_stall <= (stall_left > 0);
            end
        end
    end

    // Compare every result beat with the oldest outstanding expectation.
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result beat with none expected: status %0d handle %h payload %h",
                         $time, out_status, out_handle, out_payload);
            end else begin
                want = pending_results.pop_front();
                if (out_status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_status);
                end
                if (out_handle !== want.handle_out) begin
                    mismatch_count++;
                    $display("%0t: handle_out expected %h actual %h",
                             $time, want.handle_out, out_handle);
                end
                if (out_payload !== want.payload_out) begin
                    mismatch_count++;
                    $display("%0t: payload_out expected %h actual %h",
                             $time, want.payload_out, out_payload);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        for (int i = 0; i < ght_pkg::SLOT_COUNT; i++) begin
            table_valid[i]   = 1'b0;
            table_check[i]   = '0;
            table_payload[i] = '0;
        end
        next_stamp = 16'd1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows.
        foreach (DIRECTED[r]) begin
            send_cmd(DIRECTED[r].cmd, DIRECTED[r].handle, DIRECTED[r].payload,
                     DIRECTED[r].typed, DIRECTED[r].want);
        end

        // Mixed traffic, with one long hold on the result side partway in.
        for (int n = 0; n < 30; n++) begin
            if (n == 15) long_holds_asked = 1;
            send_random(40, 20, 25);
        end

        // Fill the table with allocates and keep knocking on it while full.
        while (full_hits < 4) send_random(100, 0, 0);

        // Pause the sender until every expected result has come back.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);

        // Release-heavy traffic frees slots again.
        for (int n = 0; n < 25; n++) send_random(10, 60, 20);

        // Closing stretch at full rate.
        idle_en = 1'b0;
        for (int n = 0; n < 25; n++) send_random(35, 25, 25);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
